/* rtl/hps_pkg.sv */
package hps_pkg;

  // Default duty resolution and fixed gain format
  localparam int DUTY_FRAC_BITS_DEF = 16;
  localparam int GAIN_FRAC_BITS     = 12;

  // Field widths
  localparam int TIME_W      = 32;
  localparam int RPM_W       = 32;
  localparam int SETPOINT_W  = 16;
  localparam int GAIN_W      = 16;
  localparam int PERIOD_W    = 16;
  localparam int COMPARE_W   = 16;
  localparam int OUT_DUTY_W  = 17;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // Register reset values
  localparam logic [RPM_W-1:0]    RPM_SCALE_RST  = 32'd425000000;
  localparam logic [GAIN_W-1:0]   GAIN_RST       = 16'd2048;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd4249;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RPM_SCALE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN       = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PWM_PERIOD = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEED,
    ST_MUL,
    ST_STEP,
    ST_UPD,
    ST_LOAD
  } hps_state_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } hps_div_sts_t;

endpackage

/* rtl/hall_period_speed_p_duty_loop.sv */
// Hall-period proportional speed loop.
//
// Input channel (in_*): one transfer per Hall edge with the captured timer
// count, an optional new speed setpoint (flagged in in_tuser). Output
// channel (out_*): one transfer per edge whose interval is nonzero, with the
// PWM compare value, the measured speed and the new duty. An edge with a
// zero interval gives no output; its setpoint is held until the next edge
// that does.
//
// Throughput: one edge at a time. After a nonzero-interval edge the block
// takes no new input transfer until its result is loaded into the output
// register. Two bit-serial divisions on one shared divider do the work: a
// 32-bit one for the speed and, unless the target is zero, a NUM_W-bit one
// for the duty step, with NUM_W = 48 + max(DUTY_FRAC_BITS - 12, 0). A
// zero-interval edge is taken without leaving the idle state.
// The result sits in an output register; the next edge is accepted while it
// waits. If the receiver stalls, the block holds the following result until
// the register frees. Reset (rst_n, synchronous) clears the duty, target,
// pending setpoint and previous capture, and loads register defaults.
// Configuration writes (cfg_we/cfg_addr/cfg_wdata) take effect in the cycle after the write.
module hall_period_speed_p_duty_loop #(
  parameter int DUTY_FRAC_BITS = hps_pkg::DUTY_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: edge_time[31:0], setpoint_rpm[47:32]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: has_setpoint[0]
  input  logic                             in_tuser,
  // out_tdata: compare_value[15:0], measured_rpm[47:16], duty_fraction[64:48]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [hps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hps_pkg::*;

  localparam int DUTY_W = DUTY_FRAC_BITS + 1;
  localparam int QS_W   = DUTY_W + 1;
  localparam int SHL    = (DUTY_FRAC_BITS >= GAIN_FRAC_BITS) ?
                          DUTY_FRAC_BITS - GAIN_FRAC_BITS : 0;
  localparam int SHR    = (DUTY_FRAC_BITS < GAIN_FRAC_BITS) ?
                          GAIN_FRAC_BITS - DUTY_FRAC_BITS : 0;
  localparam int NUM_W  = GAIN_W + RPM_W + SHL;
  localparam int DSR_W  = RPM_W;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int PROD_W = DUTY_W + PERIOD_W;
  localparam logic [QS_W-1:0] DUTY_FULL = QS_W'(1) << DUTY_FRAC_BITS;

  hps_state_t state_r, state_nxt;

  logic [RPM_W-1:0]      rpm_scale_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [PERIOD_W-1:0]   period_r;
  logic [TIME_W-1:0]     prev_r;
  logic [DUTY_W-1:0]     duty_r, duty_nxt;
  logic [SETPOINT_W-1:0] target_r;
  logic                  pend_vld_r;
  logic [SETPOINT_W-1:0] pend_spd_r;
  logic [RPM_W-1:0]      speed_r;
  logic                  up_r;
  logic                  out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [TIME_W-1:0]     in_edge;
  logic [SETPOINT_W-1:0] in_sp;
  logic [TIME_W-1:0]     delta;
  logic                  in_xfer;
  logic                  delta_zero;

  logic                  div_start;
  logic [CNT_W-1:0]      div_iters;
  logic [NUM_W-1:0]      div_dvd;
  logic [DSR_W-1:0]      div_dsr;
  logic [NUM_W-1:0]      div_q;
  hps_div_sts_t          div_sts;

  logic                  err_up;
  logic [RPM_W-1:0]      err_mag;
  logic [GAIN_W+RPM_W-1:0] step_num;
  logic [QS_W-1:0]       q_sat;
  logic [QS_W-1:0]       duty_ext;
  logic [PROD_W-1:0]     cmp_prod;
  logic                  load_out;

  assign in_edge    = in_tdata[TIME_W-1:0];
  assign in_sp      = in_tdata[TIME_W +: SETPOINT_W];
  assign delta      = in_edge - prev_r;
  assign delta_zero = (delta == '0);
  assign in_xfer    = in_tvalid && in_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer && !delta_zero) state_nxt = ST_SPEED;
      ST_SPEED: if (div_sts.done) state_nxt = (target_r == '0) ? ST_UPD : ST_MUL;
      ST_MUL:   state_nxt = ST_STEP;
      ST_STEP:  if (div_sts.done) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_LOAD;
      ST_LOAD:  if (!out_vld_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_xfer && !delta_zero;
      end
      ST_MUL:  div_start = 1'b1;
      ST_LOAD: load_out  = !out_vld_r || out_tready;
      default: ;
    endcase
  end

  // Speed error and proportional numerator
  always_comb begin
    err_up   = {{(RPM_W-SETPOINT_W){1'b0}}, target_r} >= speed_r;
    err_mag  = err_up ? RPM_W'(target_r) - speed_r : speed_r - RPM_W'(target_r);
    step_num = (GAIN_W+RPM_W)'(gain_r) * (GAIN_W+RPM_W)'(err_mag);
  end

  // Divider operands: speed first, duty step second
  always_comb begin
    if (state_r == ST_MUL) begin
      div_iters = CNT_W'(NUM_W);
      div_dvd   = NUM_W'(step_num) << SHL;
      div_dsr   = DSR_W'(target_r) << SHR;
    end else begin
      div_iters = CNT_W'(RPM_W);
      div_dvd   = NUM_W'(rpm_scale_r) << (NUM_W - RPM_W);
      div_dsr   = delta;
    end
  end

  hps_div #(
    .DVD_W (NUM_W),
    .DSR_W (DSR_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .iters    (div_iters),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // Duty update with saturation; a large step clamps, a zero target gives zero duty
  always_comb begin
    q_sat    = (|div_q[NUM_W-1:QS_W]) ? '1 : div_q[QS_W-1:0];
    duty_ext = QS_W'(duty_r);
    duty_nxt = duty_r;
    if (target_r == '0) begin
      duty_nxt = '0;
    end else if (up_r) begin
      if (q_sat >= DUTY_FULL - duty_ext) duty_nxt = DUTY_W'(DUTY_FULL);
      else                               duty_nxt = DUTY_W'(duty_ext + q_sat);
    end else begin
      if (q_sat >= duty_ext) duty_nxt = '0;
      else                   duty_nxt = DUTY_W'(duty_ext - q_sat);
    end
  end

  assign cmp_prod = PROD_W'(duty_r) * PROD_W'(period_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_scale_r <= RPM_SCALE_RST;
      gain_r      <= GAIN_RST;
      period_r    <= PWM_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RPM_SCALE:  rpm_scale_r <= cfg_wdata;
        REG_GAIN:       gain_r      <= cfg_wdata[GAIN_W-1:0];
        REG_PWM_PERIOD: period_r    <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prev_r     <= '0;
      duty_r     <= '0;
      target_r   <= '0;
      pend_vld_r <= 1'b0;
      pend_spd_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        prev_r <= in_edge;
        if (delta_zero) begin
          if (in_tuser) begin
            pend_vld_r <= 1'b1;
            pend_spd_r <= in_sp;
          end
        end else begin
          if (in_tuser)        target_r <= in_sp;
          else if (pend_vld_r) target_r <= pend_spd_r;
          pend_vld_r <= 1'b0;
        end
      end
      if (state_r == ST_UPD) duty_r <= duty_nxt;
      if (load_out)          out_vld_r <= 1'b1;
      else if (out_tready)   out_vld_r <= 1'b0;
    end
  end

  // Working and output data
  always_ff @(posedge clk) begin
    if (state_r == ST_SPEED && div_sts.done) speed_r <= div_q[RPM_W-1:0];
    if (state_r == ST_MUL) up_r <= err_up;
    if (load_out) begin
      out_data_r <= {{(OUT_TDATA_W-OUT_DUTY_W-RPM_W-COMPARE_W){1'b0}},
                     OUT_DUTY_W'(duty_r), speed_r,
                     cmp_prod[DUTY_FRAC_BITS +: COMPARE_W]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_sts.busy)
    else $error("divider busy while idle");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    QS_W'(duty_r) <= DUTY_FULL)
    else $error("duty above full scale");

  a_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && delta_zero |=> state_r == ST_IDLE && $stable(duty_r))
    else $error("zero interval started work");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_vld_r || out_tready)
    else $error("result overwrote pending output");

  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD && target_r == '0 |-> duty_r == '0)
    else $error("duty nonzero with zero target");

endmodule

/* rtl/hps_div.sv */
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned; when done rises, the low iters bits of the shift register
// hold the quotient.
module hps_div #(
  parameter int DVD_W = 48,
  parameter int DSR_W = 32,
  parameter int CNT_W = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CNT_W-1:0]     iters,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DSR_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output hps_pkg::hps_div_sts_t sts
);
  import hps_pkg::*;

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = trial >= {1'b0, dsr_r};
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = iters;
    end else if (cnt_r != '0) begin
      dvd_nxt  = {dvd_r[DVD_W-2:0], ge};
      rem_nxt  = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = dvd_r;
  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;

endmodule
